// ===== hw/rtl/akws_pkg.sv =====
// Shared widths, register codes and constants of the wheel speed kinematics block.
`timescale 1ns / 1ps
package akws_pkg;

  localparam int VW     = 16;   // linear speed
  localparam int WW     = 16;   // yaw rate
  localparam int AW     = 15;   // articulation angle
  localparam int OW     = 32;   // wheel speed result
  localparam int TW     = 12;   // track width
  localparam int RW     = 10;   // wheel radius
  localparam int LW     = 12;   // joint distances
  localparam int CFG_IW = 8;
  localparam int CFG_DW = 16;

  localparam int CW     = 34;   // CORDIC datapath width, Q30
  localparam int ATAN_N = 24;

  typedef enum logic [CFG_IW-1:0] {
    REG_TRACK  = 8'd0,
    REG_RADIUS = 8'd1,
    REG_FRONT  = 8'd2,
    REG_REAR   = 8'd3
  } cfg_reg_t;

  localparam logic [TW-1:0] TRACK_RST  = 12'd500;
  localparam logic [RW-1:0] RADIUS_RST = 10'd100;
  localparam logic [LW-1:0] FRONT_RST  = 12'd300;
  localparam logic [LW-1:0] REAR_RST   = 12'd300;

  localparam logic signed [CW-1:0] Q30_GAIN    = 34'sh026DD3B6A;
  localparam logic signed [CW-1:0] Q30_HALF_PI = 34'sh06487ED51;
  localparam logic signed [CW-1:0] Q30_PI      = 34'sh0C90FDAA2;

  localparam logic [31:0] ATAN_Q30 [ATAN_N] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
    32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
    32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
    32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

endpackage

// ===== hw/rtl/akws_in_if.sv =====
// Command channel: body speed, yaw rate and articulation angle.
`timescale 1ns / 1ps
interface akws_in_if;
  import akws_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [VW-1:0] linear_speed;
  logic signed [WW-1:0] yaw_rate;
  logic signed [AW-1:0] joint_angle;

  modport source (output valid, linear_speed, yaw_rate, joint_angle, input ready);
  modport sink   (input valid, linear_speed, yaw_rate, joint_angle, output ready);
endinterface

// ===== hw/rtl/akws_out_if.sv =====
// Result channel: four wheel speeds and the saturation flag.
`timescale 1ns / 1ps
interface akws_out_if;
  import akws_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [OW-1:0] front_left_speed;
  logic signed [OW-1:0] front_right_speed;
  logic signed [OW-1:0] rear_left_speed;
  logic signed [OW-1:0] rear_right_speed;
  logic                 saturated;

  modport source (output valid, front_left_speed, front_right_speed, rear_left_speed,
                  rear_right_speed, saturated, input ready);
  modport sink   (input valid, front_left_speed, front_right_speed, rear_left_speed,
                  rear_right_speed, saturated, output ready);
endinterface

// ===== hw/rtl/akws_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, several lanes side by side.
`timescale 1ns / 1ps
module akws_div #(
  parameter int NW    = 48,
  parameter int DW    = 23,
  parameter int LANES = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [LANES-1:0][NW-1:0]   in_mag,
  input  logic [LANES-1:0][DW-1:0]   in_den,
  input  logic [LANES-1:0]           in_neg,
  output logic                       out_valid,
  output logic [LANES-1:0][NW-1:0]   out_quo,
  output logic [LANES-1:0]           out_neg
);

  logic [NW-1:0]                   vld_r;
  logic [LANES-1:0][NW-1:0]        nq_r  [NW];
  logic [LANES-1:0][DW-1:0]        rem_r [NW];
  logic [LANES-1:0][DW-1:0]        den_r [NW];
  logic [LANES-1:0]                neg_r [NW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NW-2:0], in_valid};
    end
  end

  genvar s, l;
  generate
    for (s = 0; s < NW; s++) begin : g_stage
      logic [LANES-1:0][NW-1:0] nq_src;
      logic [LANES-1:0][DW-1:0] rem_src;
      logic [LANES-1:0][DW-1:0] den_src;
      logic [LANES-1:0]         neg_src;
      if (s == 0) begin : g_first
        assign nq_src  = in_mag;
        assign rem_src = '0;
        assign den_src = in_den;
        assign neg_src = in_neg;
      end else begin : g_rest
        assign nq_src  = nq_r[s-1];
        assign rem_src = rem_r[s-1];
        assign den_src = den_r[s-1];
        assign neg_src = neg_r[s-1];
      end
      for (l = 0; l < LANES; l++) begin : g_lane
        logic [DW:0]   trial;
        logic          ge;
        logic [DW:0]   diff;
        assign trial = {rem_src[l], nq_src[l][NW-1]};
        assign ge    = trial >= {1'b0, den_src[l]};
        assign diff  = trial - {1'b0, den_src[l]};
        always_ff @(posedge clk) begin
          if (en) begin
            nq_r[s][l]  <= {nq_src[l][NW-2:0], ge};
            rem_r[s][l] <= ge ? diff[DW-1:0] : trial[DW-1:0];
            den_r[s][l] <= den_src[l];
            neg_r[s][l] <= neg_src[l];
          end
        end
      end
    end
  endgenerate

  assign out_valid = vld_r[NW-1];
  assign out_quo   = nq_r[NW-1];
  assign out_neg   = neg_r[NW-1];

endmodule

// ===== hw/rtl/articulated_wheel_speed_kinematics.sv =====
// Top level: articulated two-axle differential drive, body command to four wheel speeds.
`timescale 1ns / 1ps
// One command enters every cycle while in_bus.ready is high, and one result leaves per
// command, in order. Between acceptance and the result standing on out_bus lie an input
// register, the angle reduction stage, one CORDIC stage per rotation, five stages of
// rotation, multiply and numerator arithmetic, then 48 divider stages (one quotient bit
// each) and the output register. The 48-bit restoring divider sets the depth; throughput
// is one transaction per cycle while the pipeline is not held. A skid register behind the
// output register lets the pipeline keep taking commands while one result waits; the
// pipeline holds only once two results are waiting. Configuration writes (cfg_ready is
// always high) take effect at once and must only be issued while the pipeline is empty;
// a register written with zero is used as one, and writes to unknown indices are dropped.
module articulated_wheel_speed_kinematics #(
  parameter int ROTATION_STAGES = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  akws_in_if.sink                       in_bus,
  akws_out_if.source                    out_bus,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [akws_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [akws_pkg::CFG_DW-1:0]   cfg_data
);
  import akws_pkg::*;

  localparam int NROT = (ROTATION_STAGES > ATAN_N) ? ATAN_N : ROTATION_STAGES;
  localparam int NW   = 48;   // divider numerator width
  localparam int DW   = 23;   // divider denominator width (2*Lr*R)
  localparam int PW   = 61;   // rotation product width

  typedef struct packed {
    logic signed [32:0] fl;   // front left numerator, Q16
    logic signed [32:0] fr;   // front right numerator, Q16
    logic signed [27:0] vx;   // v in Q12
    logic signed [28:0] vy;   // Lf*w in Q12
  } pay_t;

  typedef struct packed {
    logic [3:0][OW-1:0] spd;
    logic               sat;
  } res_t;

  // ---------------------------------------------------------------- configuration
  logic [TW-1:0] track_r;
  logic [RW-1:0] radius_r;
  logic [LW-1:0] front_r;
  logic [LW-1:0] rear_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      track_r  <= TRACK_RST;
      radius_r <= RADIUS_RST;
      front_r  <= FRONT_RST;
      rear_r   <= REAR_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TRACK:  track_r  <= cfg_data[TW-1:0];
        REG_RADIUS: radius_r <= cfg_data[RW-1:0];
        REG_FRONT:  front_r  <= cfg_data[LW-1:0];
        REG_REAR:   rear_r   <= cfg_data[LW-1:0];
        default: ;  // drop writes to unknown registers
      endcase
    end
  end

  // zero stands for the lower bound of one
  logic [TW-1:0] t_eff;
  logic [RW-1:0] r_eff;
  logic [LW-1:0] lf_eff;
  logic [LW-1:0] lr_eff;
  assign t_eff  = (track_r  == '0) ? TW'(1) : track_r;
  assign r_eff  = (radius_r == '0) ? RW'(1) : radius_r;
  assign lf_eff = (front_r  == '0) ? LW'(1) : front_r;
  assign lr_eff = (rear_r   == '0) ? LW'(1) : rear_r;

  // whole pipeline advances together; hold only when the skid register is occupied
  logic en;
  logic skid_vld_r;
  assign en           = !skid_vld_r;
  assign in_bus.ready = en;

  // ---------------------------------------------------------------- stage A: capture
  logic                 a_vld_r;
  logic signed [VW-1:0] a_v_r;
  logic signed [WW-1:0] a_w_r;
  logic signed [AW-1:0] a_ang_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_v_r   <= in_bus.linear_speed;
      a_w_r   <= in_bus.yaw_rate;
      a_ang_r <= in_bus.joint_angle;
    end
  end

  // ---------------------------------------------------------------- stage B: reduce angle
  logic signed [CW-1:0] z_raw;
  logic signed [CW-1:0] z_red;
  logic                 flip;
  logic signed [28:0]   wt;
  logic signed [31:0]   wt8;
  logic signed [31:0]   vf;
  pay_t                 b_pay;

  assign z_raw = $signed({a_ang_r[AW-1], a_ang_r, 18'b0});

  always_comb begin
    priority if (z_raw > Q30_HALF_PI) begin
      z_red = z_raw - Q30_PI;
      flip  = 1'b1;
    end else if (z_raw < -Q30_HALF_PI) begin
      z_red = z_raw + Q30_PI;
      flip  = 1'b1;
    end else begin
      z_red = z_raw;
      flip  = 1'b0;
    end
  end

  assign wt       = $signed({1'b0, t_eff}) * a_w_r;
  assign wt8      = {wt, 3'b0};
  assign vf       = {a_v_r, 16'b0};
  assign b_pay.fl = $signed({vf[31], vf}) - $signed({wt8[31], wt8});
  assign b_pay.fr = $signed({vf[31], vf}) + $signed({wt8[31], wt8});
  assign b_pay.vx = {a_v_r, 12'b0};
  assign b_pay.vy = $signed({1'b0, lf_eff}) * a_w_r;

  logic                 b_vld_r;
  logic signed [CW-1:0] b_z_r;
  logic                 b_flip_r;
  pay_t                 b_pay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (en) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_z_r    <= z_red;
      b_flip_r <= flip;
      b_pay_r  <= b_pay;
    end
  end

  // ---------------------------------------------------------------- CORDIC rotations
  logic                 cr_vld_r  [NROT];
  logic signed [CW-1:0] cr_x_r    [NROT];
  logic signed [CW-1:0] cr_y_r    [NROT];
  logic signed [CW-1:0] cr_z_r    [NROT];
  logic                 cr_flip_r [NROT];
  pay_t                 cr_pay_r  [NROT];

  genvar k;
  generate
    for (k = 0; k < NROT; k++) begin : g_rot
      logic                 vld_src;
      logic signed [CW-1:0] x_src;
      logic signed [CW-1:0] y_src;
      logic signed [CW-1:0] z_src;
      logic                 flip_src;
      pay_t                 pay_src;
      logic signed [CW-1:0] ang;
      if (k == 0) begin : g_first
        assign vld_src  = b_vld_r;
        assign x_src    = Q30_GAIN;
        assign y_src    = '0;
        assign z_src    = b_z_r;
        assign flip_src = b_flip_r;
        assign pay_src  = b_pay_r;
      end else begin : g_rest
        assign vld_src  = cr_vld_r[k-1];
        assign x_src    = cr_x_r[k-1];
        assign y_src    = cr_y_r[k-1];
        assign z_src    = cr_z_r[k-1];
        assign flip_src = cr_flip_r[k-1];
        assign pay_src  = cr_pay_r[k-1];
      end
      assign ang = $signed({2'b00, ATAN_Q30[k]});

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          cr_vld_r[k] <= 1'b0;
        end else if (en) begin
          cr_vld_r[k] <= vld_src;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          if (!z_src[CW-1]) begin
            cr_x_r[k] <= x_src - (y_src >>> k);
            cr_y_r[k] <= y_src + (x_src >>> k);
            cr_z_r[k] <= z_src - ang;
          end else begin
            cr_x_r[k] <= x_src + (y_src >>> k);
            cr_y_r[k] <= y_src - (x_src >>> k);
            cr_z_r[k] <= z_src + ang;
          end
          cr_flip_r[k] <= flip_src;
          cr_pay_r[k]  <= pay_src;
        end
      end
    end
  endgenerate

  // ---------------------------------------------------------------- stage C: undo reduction
  logic signed [CW-1:0] c_full;
  logic signed [CW-1:0] s_full;
  assign c_full = cr_flip_r[NROT-1] ? -cr_x_r[NROT-1] : cr_x_r[NROT-1];
  assign s_full = cr_flip_r[NROT-1] ? -cr_y_r[NROT-1] : cr_y_r[NROT-1];

  logic               c_vld_r;
  logic signed [31:0] c_cos_r;
  logic signed [31:0] c_sin_r;
  pay_t               c_pay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (en) begin
      c_vld_r <= cr_vld_r[NROT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // |cos|,|sin| stay below 2^31 in Q30
      c_cos_r <= c_full[31:0];
      c_sin_r <= s_full[31:0];
      c_pay_r <= cr_pay_r[NROT-1];
    end
  end

  // ---------------------------------------------------------------- stage D: rotation products
  logic               d_vld_r;
  logic signed [PW-1:0] d_cvx_r;
  logic signed [PW-1:0] d_svy_r;
  logic signed [PW-1:0] d_cvy_r;
  logic signed [PW-1:0] d_svx_r;
  pay_t               d_pay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else if (en) begin
      d_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_cvx_r <= c_cos_r * c_pay_r.vx;
      d_svy_r <= c_sin_r * c_pay_r.vy;
      d_cvy_r <= c_cos_r * c_pay_r.vy;
      d_svx_r <= c_sin_r * c_pay_r.vx;
      d_pay_r <= c_pay_r;
    end
  end

  // ---------------------------------------------------------------- stage E: round to Q16
  logic signed [PW:0] sum_x;
  logic signed [PW:0] sum_y;
  assign sum_x = (PW+1)'(d_cvx_r) + (PW+1)'(d_svy_r) + (PW+1)'(33554432);
  assign sum_y = (PW+1)'(d_cvy_r) - (PW+1)'(d_svx_r) + (PW+1)'(33554432);

  logic               e_vld_r;
  logic signed [33:0] e_vrx_r;
  logic signed [33:0] e_vry_r;
  pay_t               e_pay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else if (en) begin
      e_vld_r <= d_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // arithmetic shift by 26; the rotated speeds fit in 34 bits
      e_vrx_r <= sum_x[59:26];
      e_vry_r <= sum_y[59:26];
      e_pay_r <= d_pay_r;
    end
  end

  // ---------------------------------------------------------------- stage F: rear numerator terms
  logic               f_vld_r;
  logic signed [NW-1:0] f_rv_r;
  logic signed [NW-1:0] f_rw_r;
  pay_t               f_pay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else if (en) begin
      f_vld_r <= e_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_rv_r  <= e_vrx_r * $signed({1'b0, lr_eff, 1'b0});
      f_rw_r  <= e_vry_r * $signed({1'b0, t_eff});
      f_pay_r <= e_pay_r;
    end
  end

  // ---------------------------------------------------------------- stage G: sign, magnitude, half
  logic [DW-1:0]                den_front;
  logic [DW-1:0]                den_rear;
  logic [3:0][NW-1:0]           num;
  logic [3:0][DW-1:0]           den;
  logic [3:0][NW-1:0]           mag;
  logic [3:0]                   neg;

  assign den_front = DW'(r_eff);
  assign den_rear  = {lr_eff, 1'b0} * r_eff;

  always_comb begin
    num[0] = NW'(f_pay_r.fl);
    num[1] = NW'(f_pay_r.fr);
    num[2] = f_rv_r + f_rw_r;
    num[3] = f_rv_r - f_rw_r;
    den[0] = den_front;
    den[1] = den_front;
    den[2] = den_rear;
    den[3] = den_rear;
    for (int i = 0; i < 4; i++) begin
      neg[i] = num[i][NW-1];
      mag[i] = (neg[i] ? (NW'(0) - num[i]) : num[i]) + NW'(den[i] >> 1);
    end
  end

  logic               g_vld_r;
  logic [3:0][NW-1:0] g_mag_r;
  logic [3:0][DW-1:0] g_den_r;
  logic [3:0]         g_neg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_vld_r <= 1'b0;
    end else if (en) begin
      g_vld_r <= f_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_mag_r <= mag;
      g_den_r <= den;
      g_neg_r <= neg;
    end
  end

  // ---------------------------------------------------------------- divider
  logic               q_vld;
  logic [3:0][NW-1:0] q_quo;
  logic [3:0]         q_neg;

  akws_div #(
    .NW    (NW),
    .DW    (DW),
    .LANES (4)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (g_vld_r),
    .in_mag    (g_mag_r),
    .in_den    (g_den_r),
    .in_neg    (g_neg_r),
    .out_valid (q_vld),
    .out_quo   (q_quo),
    .out_neg   (q_neg)
  );

  // ---------------------------------------------------------------- saturate to Q16.16
  res_t       pipe_res;
  logic [3:0] clip;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (!q_neg[i]) begin
        clip[i]         = q_quo[i] > NW'(32'h7FFF_FFFF);
        pipe_res.spd[i] = clip[i] ? 32'h7FFF_FFFF : q_quo[i][OW-1:0];
      end else begin
        clip[i]         = q_quo[i] > NW'(32'h8000_0000);
        pipe_res.spd[i] = clip[i] ? 32'h8000_0000 : (32'd0 - q_quo[i][OW-1:0]);
      end
    end
    pipe_res.sat = |clip;
  end

  // ---------------------------------------------------------------- output and skid registers
  logic out_vld_r;
  res_t out_res_r;
  res_t skid_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (out_vld_r && out_bus.ready) begin
        // transaction taken: refill from skid first, else from the pipeline
        if (skid_vld_r) begin
          out_res_r  <= skid_res_r;
          skid_vld_r <= 1'b0;
        end else if (q_vld) begin
          out_res_r <= pipe_res;
        end else begin
          out_vld_r <= 1'b0;
        end
      end else if (!out_vld_r) begin
        if (en && q_vld) begin
          out_res_r <= pipe_res;
          out_vld_r <= 1'b1;
        end
      end else if (en && q_vld) begin
        // output waiting: park the arriving result
        skid_res_r <= pipe_res;
        skid_vld_r <= 1'b1;
      end
    end
  end

  assign out_bus.valid             = out_vld_r;
  assign out_bus.front_left_speed  = out_res_r.spd[0];
  assign out_bus.front_right_speed = out_res_r.spd[1];
  assign out_bus.rear_left_speed   = out_res_r.spd[2];
  assign out_bus.rear_right_speed  = out_res_r.spd[3];
  assign out_bus.saturated         = out_res_r.sat;

endmodule

// ===== tb/articulated_wheel_speed_kinematics_test.sv =====
// Self-checking testbench for the articulated wheel speed kinematics block.
`timescale 1ns / 1ps
module articulated_wheel_speed_kinematics_test;
  import akws_pkg::*;

  localparam int STAGES  = 16;
  localparam int LATENCY = 72;
  localparam int DRAIN   = LATENCY + 40;

  // one expected set of wheel speeds
  typedef struct packed {
    logic signed [OW-1:0] fl;
    logic signed [OW-1:0] fr;
    logic signed [OW-1:0] rl;
    logic signed [OW-1:0] rr;
    logic                 sat;
  } wheel_set_t;

  // one directed command; has_exp marks rows with a typed-in answer
  typedef struct {
    logic signed [VW-1:0] v;
    logic signed [WW-1:0] w;
    logic signed [AW-1:0] a;
    bit                   has_exp;
    wheel_set_t           exp;
  } cmd_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data = '0;

  akws_in_if  in_bus ();
  akws_out_if out_bus ();

  articulated_wheel_speed_kinematics #(.ROTATION_STAGES(STAGES)) dut (
    .clk(clk), .rst_n(rst_n), .in_bus(in_bus), .out_bus(out_bus),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // geometry shadow of the block's registers
  logic [TW-1:0] track_mm;
  logic [RW-1:0] radius_mm;
  logic [LW-1:0] front_mm;
  logic [LW-1:0] rear_mm;

  wheel_set_t speed_queue[$];
  int unsigned error_count = 0;
  bit  sink_idle_enable = 1'b1;
  bit  sink_hold = 1'b0;
  bit  source_idle_enable = 1'b1;

  localparam longint ATAN_TAB [ATAN_N] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
    64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
    64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
    64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
    64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
  };

  initial begin
    forever #6 clk = ~clk;
  end

  // hard stop well past the slowest correct run
  initial begin
    #40ms;
    $display("FAIL articulated_wheel_speed_kinematics");
    $finish;
  end

  // SystemVerilog >>> on longint already floors toward minus infinity
  function automatic longint round_div(longint n, longint d);
    longint mag;
    longint q;
    mag = (n < 0) ? -n : n;
    q = (mag + d / 2) / d;
    return (n < 0) ? -q : q;
  endfunction

  function automatic logic signed [OW-1:0] clip32(longint x, ref logic flag);
    if (x > 64'sd2147483647) begin
      flag = 1'b1;
      return 32'sh7FFFFFFF;
    end
    if (x < -64'sd2147483648) begin
      flag = 1'b1;
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

  function automatic longint nonzero(longint r);
    return (r == 0) ? 1 : r;
  endfunction

  // rotate the joint velocity and divide down to wheel speeds
  function automatic wheel_set_t wheel_speeds(logic signed [VW-1:0] vin,
                                              logic signed [WW-1:0] win,
                                              logic signed [AW-1:0] ain);
    wheel_set_t r;
    longint v, w, t, rad, lf, lr, z, x, y, nx, c, s, vx, vy, vrx, vry, d;
    logic flip;
    logic flag;
    int n;
    v = vin; w = win;
    t = nonzero(track_mm); rad = nonzero(radius_mm);
    lf = nonzero(front_mm); lr = nonzero(rear_mm);
    flag = 1'b0;
    r.fl = clip32(round_div(v * 65536 - w * t * 8, rad), flag);
    r.fr = clip32(round_div(v * 65536 + w * t * 8, rad), flag);
    z = longint'(ain) * 262144;
    x = 64'h26DD3B6A; y = 0; flip = 1'b0;
    if (z > 64'sh6487ED51) begin
      z -= 64'hC90FDAA2; flip = 1'b1;
    end else if (z < -64'sh6487ED51) begin
      z += 64'hC90FDAA2; flip = 1'b1;
    end
    n = (STAGES > ATAN_N) ? ATAN_N : STAGES;
    for (int i = 0; i < n; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= ATAN_TAB[i];
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z += ATAN_TAB[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
    vx = v * 4096; vy = lf * w;
    vrx = (c * vx + s * vy + (64'sd1 << 25)) >>> 26;
    vry = (c * vy - s * vx + (64'sd1 << 25)) >>> 26;
    d = 2 * lr * rad;
    r.rl = clip32(round_div(vrx * 2 * lr + vry * t, d), flag);
    r.rr = clip32(round_div(vrx * 2 * lr - vry * t, d), flag);
    r.sat = flag;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // sink side: random backpressure plus one long hold-off
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_bus.ready <= !sink_hold && !(sink_idle_enable && $urandom_range(99) < 22);
    end
  end

  // sample results at the rising edge and compare against the oldest expectation
  always @(posedge clk) begin
    wheel_set_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (speed_queue.size() == 0) begin
        $display("unexpected result transaction at %0t", $realtime);
        error_count++;
      end else begin
        want = speed_queue.pop_front();
        if (out_bus.front_left_speed !== want.fl)
          report_mismatch("front_left", out_bus.front_left_speed, want.fl);
        if (out_bus.front_right_speed !== want.fr)
          report_mismatch("front_right", out_bus.front_right_speed, want.fr);
        if (out_bus.rear_left_speed !== want.rl)
          report_mismatch("rear_left", out_bus.rear_left_speed, want.rl);
        if (out_bus.rear_right_speed !== want.rr)
          report_mismatch("rear_right", out_bus.rear_right_speed, want.rr);
        if (out_bus.saturated !== want.sat)
          report_mismatch("saturated", out_bus.saturated, want.sat);
      end
    end
  end

  // write one register; hold valid until the transaction is taken
  task automatic write_reg(cfg_reg_t idx, logic [CFG_DW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_TRACK:  track_mm  = val[TW-1:0];
      REG_RADIUS: radius_mm = val[RW-1:0];
      REG_FRONT:  front_mm  = val[LW-1:0];
      REG_REAR:   rear_mm   = val[LW-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // an unknown index must leave every register untouched
  task automatic write_unknown(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_geometry(logic [CFG_DW-1:0] t, logic [CFG_DW-1:0] r,
                              logic [CFG_DW-1:0] f, logic [CFG_DW-1:0] b);
    write_reg(REG_TRACK, t);
    write_reg(REG_RADIUS, r);
    write_reg(REG_FRONT, f);
    write_reg(REG_REAR, b);
  endtask

  // offer one command; keep valid high across back-to-back transactions
  task automatic send_cmd(logic signed [VW-1:0] v, logic signed [WW-1:0] w,
                          logic signed [AW-1:0] a, bit has_exp, wheel_set_t exp);
    while (source_idle_enable && $urandom_range(99) < 22) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.linear_speed <= v;
    in_bus.yaw_rate     <= w;
    in_bus.joint_angle  <= a;
    do @(posedge clk); while (!in_bus.ready);
    speed_queue.push_back(has_exp ? exp : wheel_speeds(v, w, a));
    @(negedge clk);
  endtask

  task automatic end_burst();
    in_bus.valid <= 1'b0;
  endtask

  // wait for every expected result, then cover the pipeline depth
  task automatic drain();
    end_burst();
    while (speed_queue.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  // random command: mostly legal angles, some beyond pi, full 16-bit speeds
  task automatic send_random();
    logic signed [VW-1:0] v;
    logic signed [WW-1:0] w;
    logic signed [AW-1:0] a;
    wheel_set_t none;
    none = '0;
    v = VW'($urandom);
    w = WW'($urandom);
    if ($urandom_range(9) < 8) a = $signed(15'($urandom_range(25736))) - 15'sd12868;
    else a = AW'($urandom);
    if ($urandom_range(9) == 0) v = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
    if ($urandom_range(9) == 0) w = $signed(16'($urandom_range(64))) - 16'sd32;
    send_cmd(v, w, a, 1'b0, none);
  endtask

  cmd_row_t directed_rows[$];

  initial begin
    cmd_row_t row;
    in_bus.valid = 1'b0;
    in_bus.linear_speed = '0;
    in_bus.yaw_rate = '0;
    in_bus.joint_angle = '0;
    track_mm = TRACK_RST; radius_mm = RADIUS_RST;
    front_mm = FRONT_RST; rear_mm = REAR_RST;

    // directed table: zero, speed and yaw extremes, angle extremes and beyond pi
    row = '{v: 0, w: 0, a: 0, has_exp: 1, exp: '0}; directed_rows.push_back(row);
    // v = 100 mm/s straight ahead: close to 1 rad/s on every wheel, the rear pair
    // shifted by the CORDIC residual angle
    row = '{v: 100, w: 0, a: 0, has_exp: 0, exp: '0};
    directed_rows.push_back(row);
    row = '{v: 16'sh7FFF, w: 0, a: 0, has_exp: 0, exp: '0}; directed_rows.push_back(row);
    row = '{v: 16'sh8000, w: 0, a: 0, has_exp: 0, exp: '0}; directed_rows.push_back(row);
    row = '{v: 0, w: 16'sh7FFF, a: 0, has_exp: 0, exp: '0}; directed_rows.push_back(row);
    row = '{v: 0, w: 16'sh8000, a: 0, has_exp: 0, exp: '0}; directed_rows.push_back(row);
    row = '{v: 16'sh7FFF, w: 16'sh7FFF, a: 15'sd12868, has_exp: 0, exp: '0};
    directed_rows.push_back(row);
    row = '{v: 16'sh8000, w: 16'sh8000, a: -15'sd12868, has_exp: 0, exp: '0};
    directed_rows.push_back(row);
    row = '{v: 1000, w: 4096, a: 15'sd6434, has_exp: 0, exp: '0};
    directed_rows.push_back(row);
    row = '{v: 1000, w: -4096, a: -15'sd6434, has_exp: 0, exp: '0};
    directed_rows.push_back(row);
    row = '{v: 500, w: 2048, a: 15'sh3FFF, has_exp: 0, exp: '0};
    directed_rows.push_back(row);
    row = '{v: -500, w: -2048, a: 15'sh4000, has_exp: 0, exp: '0};
    directed_rows.push_back(row);
    row = '{v: 1, w: 1, a: 15'sd6434, has_exp: 0, exp: '0}; directed_rows.push_back(row);
    row = '{v: -1, w: -1, a: 15'sd6435, has_exp: 0, exp: '0}; directed_rows.push_back(row);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i])
      send_cmd(directed_rows[i].v, directed_rows[i].w, directed_rows[i].a,
               directed_rows[i].has_exp, directed_rows[i].exp);
    drain();

    // zero registers act as one; full speed and yaw push wheels into saturation
    set_geometry(16'd0, 16'd0, 16'd0, 16'd0);
    write_unknown(8'd4, 16'hFFFF);
    write_unknown(8'hFF, 16'h1234);
    send_cmd(16'sh7FFF, 16'sh7FFF, 0, 1'b0, '0);
    send_cmd(16'sh8000, 16'sh8000, 0, 1'b0, '0);
    for (int i = 0; i < 30; i++) send_random();
    drain();

    // maximum geometry, upper bits of the data dropped
    set_geometry(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    for (int i = 0; i < 60; i++) send_random();
    drain();

    // long stretch without idling on either side, mixed geometry
    set_geometry(16'd1, 16'd1023, 16'd4095, 16'd1);
    source_idle_enable = 1'b0;
    sink_idle_enable = 1'b0;
    for (int i = 0; i < 200; i++) send_random();
    source_idle_enable = 1'b1;
    sink_idle_enable = 1'b1;
    drain();

    // receiver holds off long enough for the pipeline to fill and stall the input
    set_geometry(16'd500, 16'd100, 16'd300, 16'd300);
    fork
      begin
        sink_hold = 1'b1;
        repeat (300) @(negedge clk);
        sink_hold = 1'b0;
      end
      for (int i = 0; i < 150; i++) send_random();
    join
    drain();

    // random geometry phases
    for (int p = 0; p < 6; p++) begin
      set_geometry(16'($urandom_range(4095)), 16'($urandom_range(1023)),
                   16'($urandom_range(4095)), 16'($urandom_range(4095)));
      for (int i = 0; i < 100; i++) send_random();
      drain();
    end

    if (error_count == 0) begin
      $display("PASS articulated_wheel_speed_kinematics");
    end else begin
      $display("FAIL articulated_wheel_speed_kinematics");
    end
    $finish;
  end

endmodule
